/* src/bandpass_flattener_macros.svh */
// Assertion macros used by the bandpass flattener checker.
`ifndef BANDPASS_FLATTENER_MACROS_SVH
`define BANDPASS_FLATTENER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset.
`define BPF_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* src/bpf_pkg.sv */
// Types and constants of the bandpass flattener.
`default_nettype none
package bpf_pkg;

  localparam int ACC_W       = 40;
  localparam int OUT_W       = 24;
  localparam int CHAN_IDX_W  = 7;
  localparam int POL_IDX_W   = 2;
  localparam int STEP_W      = 16;
  localparam int CHANS_REG_W = 8;
  localparam int POLS_REG_W  = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  // gain 32, 8 fraction bits, and the factor 2 of the rounding numerator
  localparam int NORM_SHIFT  = 14;

  localparam logic ACTION_ACC  = 1'b0;
  localparam logic ACTION_NORM = 1'b1;

  localparam logic [OUT_W-1:0] OUT_POS_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] OUT_NEG_MIN = 24'h800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_STEPS = 2'd0,
    REG_NUM_CHANS = 2'd1,
    REG_NUM_POLS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  neg;
    logic                  zero;
    logic [CHAN_IDX_W-1:0] chan;
    logic [POL_IDX_W-1:0]  pol;
    logic                  last;
  } meta_t;

endpackage
`default_nettype wire

/* src/bpf_in_if.sv */
// Input sample channel of the bandpass flattener.
`default_nettype none
interface bpf_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface
`default_nettype wire

/* src/bpf_out_if.sv */
// Result channel of the bandpass flattener.
`default_nettype none
interface bpf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bpf_pkg::OUT_W-1:0]      normalized;
  logic                                  clipped;
  logic        [bpf_pkg::CHAN_IDX_W-1:0] chan_index;
  logic        [bpf_pkg::POL_IDX_W-1:0]  pol_index;
  logic                                  frame_end;

  modport source (output valid, output normalized, output clipped, output chan_index,
                  output pol_index, output frame_end, input ready);
  modport sink   (input valid, input normalized, input clipped, input chan_index,
                  input pol_index, input frame_end, output ready);
endinterface
`default_nettype wire

/* src/bandpass_flattener.sv */
// Bandpass flattener top level: accumulator memory and pipelined divider.
//
//  channel   direction  handshake        payload
//  in_ch     sink       valid / ready    action, sample
//  out_ch    source     valid / ready    normalized, clipped, chan_index, pol_index, frame_end
//  cfg       write      cfg_we           cfg_index, cfg_data
//
// One sample transfer per cycle while the result channel does not stall; a normalize result
// passes through the memory read, the multiply, the setup stage and 24 divider stages.
// Accumulate sums live in one memory with a registered read; back-to-back hits are forwarded.
// A stalled result freezes the whole pipeline and drops in_ch.ready.
// Reset clears positions and pipeline valids and sets the registers to their defaults; the accumulator is not cleared.
`default_nettype none
module bandpass_flattener #(
  parameter int MAX_CHANS   = 128,
  parameter int MAX_POLS    = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpf_pkg::CFG_W-1:0]     cfg_data,
  bpf_in_if.sink                        in_ch,
  bpf_out_if.source                     out_ch
);

  localparam int ACC_W  = bpf_pkg::ACC_W;
  localparam int OUT_W  = bpf_pkg::OUT_W;
  localparam int STEP_W = bpf_pkg::STEP_W;
  localparam int QB     = OUT_W;
  localparam int CW     = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
  localparam int PW     = (MAX_POLS > 1) ? $clog2(MAX_POLS) : 1;
  localparam int DEPTH  = MAX_POLS * MAX_CHANS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_RAW = $clog2(MAX_CHANS + 1);
  localparam int CNTW   = (CNT_RAW > bpf_pkg::CHANS_REG_W) ? CNT_RAW : bpf_pkg::CHANS_REG_W;
  localparam int PCW    = bpf_pkg::POLS_REG_W;
  localparam int PRODW  = SAMPLE_BITS + STEP_W;
  localparam int NW     = PRODW + bpf_pkg::NORM_SHIFT + 1;
  localparam int DW     = ACC_W + 1;
  localparam int DXW    = DW + QB + 1;

  logic [STEP_W-1:0]               num_steps;
  logic [bpf_pkg::CHANS_REG_W-1:0] num_chans;
  logic [PCW-1:0]                  num_pols;
  logic [CW-1:0]                   chan_pos;
  logic [PW-1:0]                   pol_pos;
  logic [STEP_W-1:0]               step_pos;
  logic                            prev_action;

  logic [STEP_W-1:0] steps_eff;
  logic [CNTW-1:0]   chans_eff;
  logic [PCW-1:0]    pols_eff;

  always_comb begin
    steps_eff = (num_steps == '0) ? STEP_W'(1) : num_steps;
    chans_eff = CNTW'(num_chans);
    if (chans_eff == '0) begin
      chans_eff = CNTW'(1);
    end else if (chans_eff > CNTW'(MAX_CHANS)) begin
      chans_eff = CNTW'(MAX_CHANS);
    end
    pols_eff = num_pols;
    if (pols_eff == '0) begin
      pols_eff = PCW'(1);
    end else if (pols_eff > PCW'(MAX_POLS)) begin
      pols_eff = PCW'(MAX_POLS);
    end
  end

  logic adv, in_fire;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  logic                   restart_pos, last;
  logic [CNTW-1:0]        c, c_inc;
  logic [PCW-1:0]         p, p_inc;
  logic [STEP_W-1:0]      s;
  logic [STEP_W:0]        s_inc;
  logic [CW-1:0]          chan_pos_next;
  logic [PW-1:0]          pol_pos_next;
  logic [STEP_W-1:0]      step_pos_next;
  logic [AW-1:0]          raddr;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;

  always_comb begin
    restart_pos = in_ch.action != prev_action;
    c = restart_pos ? '0 : CNTW'(chan_pos);
    p = restart_pos ? '0 : PCW'(pol_pos);
    s = restart_pos ? '0 : step_pos;
    if (c >= chans_eff) c = '0;
    if (p >= pols_eff) p = '0;
    if (s >= steps_eff) s = '0;
    c_inc = c + CNTW'(1);
    p_inc = p + PCW'(1);
    s_inc = {1'b0, s} + (STEP_W+1)'(1);
    last = (c_inc >= chans_eff) && (p_inc >= pols_eff) && (s_inc >= {1'b0, steps_eff});
    chan_pos_next = CW'(c_inc);
    pol_pos_next  = PW'(p);
    step_pos_next = s;
    if (c_inc >= chans_eff) begin
      chan_pos_next = '0;
      pol_pos_next  = PW'(p_inc);
      if (p_inc >= pols_eff) begin
        pol_pos_next  = '0;
        step_pos_next = (s_inc >= {1'b0, steps_eff}) ? '0 : STEP_W'(s_inc);
      end
    end
    raddr = AW'(32'(p) * MAX_CHANS + 32'(c));
    neg   = in_ch.sample[SAMPLE_BITS-1];
    mag   = neg ? (~in_ch.sample + SAMPLE_BITS'(1)) : in_ch.sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps   <= 16'd10000;
      num_chans   <= 8'd128;
      num_pols    <= 3'd4;
      chan_pos    <= '0;
      pol_pos     <= '0;
      step_pos    <= '0;
      prev_action <= bpf_pkg::ACTION_ACC;
    end else begin
      if (in_fire) begin
        chan_pos    <= chan_pos_next;
        pol_pos     <= pol_pos_next;
        step_pos    <= step_pos_next;
        prev_action <= in_ch.action;
      end
      if (cfg_we) begin
        case (cfg_index)
          bpf_pkg::REG_NUM_STEPS: begin
            num_steps <= cfg_data;
            chan_pos <= '0; pol_pos <= '0; step_pos <= '0;
          end
          bpf_pkg::REG_NUM_CHANS: begin
            num_chans <= cfg_data[bpf_pkg::CHANS_REG_W-1:0];
            chan_pos <= '0; pol_pos <= '0; step_pos <= '0;
          end
          bpf_pkg::REG_NUM_POLS: begin
            num_pols <= cfg_data[PCW-1:0];
            chan_pos <= '0; pol_pos <= '0; step_pos <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // memory stage
  logic                   v1, act1, step0_1;
  logic [SAMPLE_BITS-1:0] mag1;
  logic [AW-1:0]          addr1;
  bpf_pkg::meta_t         meta1;
  logic [ACC_W-1:0]       mem [DEPTH];
  logic [ACC_W-1:0]       rdata, fwd_data, base, wdata;
  logic                   fwd, wr_en;
  logic [ACC_W:0]         sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      fwd <= 1'b0;
    end else if (adv) begin
      v1  <= in_fire;
      fwd <= wr_en && (addr1 == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act1       <= in_ch.action;
      step0_1    <= s == '0;
      mag1       <= mag;
      addr1      <= raddr;
      meta1.neg  <= neg;
      meta1.zero <= 1'b0;
      meta1.chan <= bpf_pkg::CHAN_IDX_W'(c);
      meta1.pol  <= bpf_pkg::POL_IDX_W'(p);
      meta1.last <= last;
      fwd_data   <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr1] <= wdata;
    if (adv) rdata <= mem[raddr];
  end

  always_comb begin
    wr_en = adv && v1 && (act1 == bpf_pkg::ACTION_ACC);
    base  = fwd ? fwd_data : rdata;
    sum   = {1'b0, base} + (ACC_W+1)'(mag1);
    if (step0_1) begin
      wdata = ACC_W'(mag1);
    end else begin
      wdata = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    end
  end

  // multiply stage
  logic             v2;
  logic [PRODW-1:0] prod2;
  logic [ACC_W-1:0] den2;
  bpf_pkg::meta_t   meta2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && (act1 == bpf_pkg::ACTION_NORM);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2 <= PRODW'(mag1) * PRODW'(steps_eff);
      den2  <= base;
      meta2 <= meta1;
    end
  end

  // divider: stage 0 holds the rounding numerator and doubled divisor
  logic             vd  [0:QB];
  logic [NW-1:0]    rem [0:QB];
  logic [DW-1:0]    dv  [0:QB];
  logic [QB-1:0]    qt  [0:QB];
  logic             ovf [1:QB];
  bpf_pkg::meta_t   md  [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (adv) begin
      vd[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= (NW'(prod2) << bpf_pkg::NORM_SHIFT) + NW'(den2);
      dv[0]  <= {den2, 1'b0};
      qt[0]  <= '0;
      md[0]  <= {meta2.neg, den2 == '0, meta2.chan, meta2.pol, meta2.last};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic [DXW-1:0] dsh;
    logic           ge, ovf_in;
    assign dsh = DXW'(dv[k]) << SH;
    assign ge  = DXW'(rem[k]) >= dsh;
    if (k == 0) begin : g_first
      assign ovf_in = DXW'(rem[0]) >= (DXW'(dv[0]) << QB);
    end else begin : g_rest
      assign ovf_in = ovf[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else if (adv) begin
        vd[k+1] <= vd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= ge ? (rem[k] - NW'(dsh)) : rem[k];
        dv[k+1]  <= dv[k];
        qt[k+1]  <= qt[k] | (QB'(ge) << SH);
        ovf[k+1] <= ovf_in;
        md[k+1]  <= md[k];
      end
    end
  end

  logic [OUT_W-1:0] res;
  logic             clip;

  always_comb begin
    res  = '0;
    clip = 1'b0;
    if (md[QB].zero) begin
      res = '0;
    end else if (md[QB].neg) begin
      if (ovf[QB] || (qt[QB] > bpf_pkg::OUT_NEG_MIN)) begin
        res  = bpf_pkg::OUT_NEG_MIN;
        clip = 1'b1;
      end else begin
        res = ~qt[QB] + OUT_W'(1);
      end
    end else begin
      if (ovf[QB] || (qt[QB] > bpf_pkg::OUT_POS_MAX)) begin
        res  = bpf_pkg::OUT_POS_MAX;
        clip = 1'b1;
      end else begin
        res = qt[QB];
      end
    end
  end

  assign out_ch.valid      = vd[QB];
  assign out_ch.normalized = res;
  assign out_ch.clipped    = clip;
  assign out_ch.chan_index = md[QB].chan;
  assign out_ch.pol_index  = md[QB].pol;
  assign out_ch.frame_end  = md[QB].last;

endmodule
`default_nettype wire

/* src/bpf_checker.sv */
// Port checker of the bandpass flattener and its bind.
`default_nettype none
`include "bandpass_flattener_macros.svh"
module bpf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bpf_pkg::OUT_W-1:0] normalized,
  input logic                      clipped
);

  logic at_limit;
  assign at_limit = (normalized == bpf_pkg::OUT_POS_MAX) ||
                    (normalized == bpf_pkg::OUT_NEG_MIN);

  `BPF_ASSERT_RESET(a_reset_empty, !out_valid, "result valid right after reset")
  `BPF_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input stalled with no result")
  `BPF_ASSERT_SAME(a_clip_value, out_valid && clipped, at_limit, "clipped result not at a limit")
  `BPF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(normalized) && $stable(clipped), "stalled result changed")

endmodule

bind bandpass_flattener bpf_checker u_bpf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .normalized (out_ch.normalized),
  .clipped    (out_ch.clipped)
);
`default_nettype wire
